>>> hdl/cfbp_pkg.sv
// Shared types and constants for the contact frame base64url parser.
package cfbp_pkg;

    // One decoded step handed from the front to the back through the queue.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       last;
        logic       bad;
    } token_t;

    // Field tags carried on byte results.
    localparam logic [3:0] TAG_MAGIC     = 4'd0;
    localparam logic [3:0] TAG_VERSION   = 4'd1;
    localparam logic [3:0] TAG_ID_LEN    = 4'd2;
    localparam logic [3:0] TAG_ID        = 4'd3;
    localparam logic [3:0] TAG_EP_LEN    = 4'd4;
    localparam logic [3:0] TAG_EP        = 4'd5;
    localparam logic [3:0] TAG_FLAGS     = 4'd6;
    localparam logic [3:0] TAG_SIG_LO    = 4'd7;
    localparam logic [3:0] TAG_SIG_HI    = 4'd8;
    localparam logic [3:0] TAG_SIGNALING = 4'd9;
    localparam logic [3:0] TAG_KEY       = 4'd10;
    localparam logic [3:0] TAG_SIGNATURE = 4'd11;

    // Status codes carried on the final status result.
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_CHAR  = 4'd1;
    localparam logic [3:0] ST_SHORT     = 4'd2;
    localparam logic [3:0] ST_MAGIC     = 4'd3;
    localparam logic [3:0] ST_VERSION   = 4'd4;
    localparam logic [3:0] ST_ID        = 4'd5;
    localparam logic [3:0] ST_ENDPOINT  = 4'd6;
    localparam logic [3:0] ST_SIGNALING = 4'd7;
    localparam logic [3:0] ST_TAIL      = 4'd8;

    // Frame layout constants.
    localparam logic [7:0] FRAME_MAGIC [4] = '{8'h4C, 8'h50, 8'h51, 8'h31};
    localparam logic [7:0] FRAME_VERSION     = 8'h01;
    localparam logic [7:0] MAX_NAME_LEN      = 8'd128;
    localparam logic [15:0] MAX_SIGNALING_LEN = 16'd256;
    localparam logic [8:0] MAGIC_BYTES       = 9'd4;
    localparam logic [8:0] KEY_BYTES         = 9'd32;
    localparam logic [8:0] SIG_BYTES         = 9'd64;
    localparam logic [6:0] MIN_FRAME         = 7'd102;
    localparam logic [6:0] TOTAL_MAX         = 7'd127;

endpackage

>>> hdl/cfbp_front.sv
// Front end: accepts characters, decodes base64url and emits tokens for decoded bytes and text ends.
module cfbp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_character,
    input  logic              s_last_char,
    output logic              push_valid,
    input  logic              push_ready,
    output cfbp_pkg::token_t  push_data
);
    import cfbp_pkg::*;

    logic [5:0]  lo_bits_reg;
    logic [2:0]  lo_cnt_reg;
    logic        bad_reg;

    logic [6:0]  sx;
    logic [11:0] bit_buf;
    logic [3:0]  cnt_sum;
    logic [2:0]  cnt_left;
    logic [11:0] shifted;
    logic [5:0]  lo_mask;
    logic [5:0]  lo_bits_next;
    logic        has_byte;
    logic        accept;

    // Map one character to {valid, sextet}.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        case (c) inside
            [8'h41:8'h5A]: r = {1'b1, 6'(c - 8'h41)};
            [8'h61:8'h7A]: r = {1'b1, 6'(c - 8'h61 + 8'd26)};
            [8'h30:8'h39]: r = {1'b1, 6'(c - 8'h30 + 8'd52)};
            8'h2D:         r = {1'b1, 6'd62};
            8'h5F:         r = {1'b1, 6'd63};
            default:       r = 7'd0;
        endcase
        return r;
    endfunction

    // Bit buffer: append six bits, split off a byte once eight are held.
    always_comb begin
        sx       = sextet_of(s_character);
        bit_buf  = {lo_bits_reg, sx[5:0]};
        cnt_sum  = {1'b0, lo_cnt_reg} + 4'd6;
        has_byte = !bad_reg && sx[6] && (cnt_sum >= 4'd8);
        cnt_left = has_byte ? 3'(cnt_sum - 4'd8) : 3'(cnt_sum);
        shifted  = bit_buf >> cnt_left;
        lo_mask  = 6'((7'd1 << cnt_left) - 7'd1);
        lo_bits_next = bit_buf[5:0] & lo_mask;
    end

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Only steps that yield a byte or end the text go into the queue.
    assign push_valid         = s_valid && (has_byte || s_last_char);
    assign push_data.has_byte = has_byte;
    assign push_data.data     = shifted[7:0];
    assign push_data.last     = s_last_char;
    assign push_data.bad      = bad_reg || !sx[6];

    // Decoder state; the last character returns it to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_bits_reg <= 6'd0;
            lo_cnt_reg  <= 3'd0;
            bad_reg     <= 1'b0;
        end else if (accept) begin
            if (s_last_char) begin
                lo_bits_reg <= 6'd0;
                lo_cnt_reg  <= 3'd0;
                bad_reg     <= 1'b0;
            end else if (!bad_reg) begin
                if (sx[6]) begin
                    lo_bits_reg <= lo_bits_next;
                    lo_cnt_reg  <= cnt_left;
                end else begin
                    bad_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hdl/cfbp_queue.sv
// Small first-word-fall-through queue of tokens between the front and the back.
module cfbp_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  cfbp_pkg::token_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output cfbp_pkg::token_t  pop_data
);
    import cfbp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    token_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage write.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/cfbp_back.sv
// Back end: parses decoded bytes as a contact frame and drives the result register.
module cfbp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tok_valid,
    output logic              tok_pop,
    input  cfbp_pkg::token_t  tok,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_status,
    output logic [3:0]        m_field_tag,
    output logic [7:0]        m_byte_value,
    output logic [3:0]        m_status_code,
    output logic              m_frame_ok,
    output logic              m_last_result
);
    import cfbp_pkg::*;

    typedef enum logic [12:0] {
        PH_MAGIC     = 13'b0000000000001,
        PH_VERSION   = 13'b0000000000010,
        PH_ID_LEN    = 13'b0000000000100,
        PH_ID        = 13'b0000000001000,
        PH_EP_LEN    = 13'b0000000010000,
        PH_EP        = 13'b0000000100000,
        PH_FLAGS     = 13'b0000001000000,
        PH_SIG_LO    = 13'b0000010000000,
        PH_SIG_HI    = 13'b0000100000000,
        PH_SIG       = 13'b0001000000000,
        PH_KEY       = 13'b0010000000000,
        PH_SIGNATURE = 13'b0100000000000,
        PH_DONE      = 13'b1000000000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  len_reg, len_next;
    logic [6:0]  total_reg, total_next;
    logic [3:0]  ferr_reg, ferr_next;
    logic        pend_reg, pend_next;

    logic        m_valid_reg, m_valid_next;
    logic        is_status_reg;
    logic [3:0]  tag_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  status_reg;
    logic        ok_reg;
    logic        lastr_reg;

    logic        emit;
    logic [8:0]  pos_inc;
    logic [15:0] slen;
    logic [7:0]  b;
    logic        out_free;
    logic        act;
    logic        byte_step;
    logic        load_byte;
    logic        load_status;
    logic        clear_frame;
    logic [3:0]  status_now;
    logic [3:0]  tag_now;

    // Field tag of the phase that a byte is parsed in.
    function automatic logic [3:0] phase_tag(input phase_t ph);
        logic [3:0] t;
        case (ph)
            PH_MAGIC:     t = TAG_MAGIC;
            PH_VERSION:   t = TAG_VERSION;
            PH_ID_LEN:    t = TAG_ID_LEN;
            PH_ID:        t = TAG_ID;
            PH_EP_LEN:    t = TAG_EP_LEN;
            PH_EP:        t = TAG_EP;
            PH_FLAGS:     t = TAG_FLAGS;
            PH_SIG_LO:    t = TAG_SIG_LO;
            PH_SIG_HI:    t = TAG_SIG_HI;
            PH_SIG:       t = TAG_SIGNALING;
            PH_KEY:       t = TAG_KEY;
            PH_SIGNATURE: t = TAG_SIGNATURE;
            default:      t = TAG_MAGIC;
        endcase
        return t;
    endfunction

    // Final status in order of precedence.
    function automatic logic [3:0] frame_status(input logic bad, input logic [6:0] total,
                                                input logic [3:0] ferr, input phase_t ph);
        logic [3:0] s;
        if (bad) begin
            s = ST_BAD_CHAR;
        end else if (total < MIN_FRAME) begin
            s = ST_SHORT;
        end else if (ferr != ST_OK) begin
            s = ferr;
        end else begin
            case (ph)
                PH_ID:                       s = ST_ID;
                PH_EP_LEN, PH_EP:            s = ST_ENDPOINT;
                PH_FLAGS:                    s = ST_TAIL;
                PH_SIG_LO, PH_SIG_HI, PH_SIG: s = ST_SIGNALING;
                PH_KEY, PH_SIGNATURE:        s = ST_TAIL;
                PH_DONE:                     s = ST_OK;
                default:                     s = ST_SHORT;
            endcase
        end
        return s;
    endfunction

    // Parse one byte against the current phase.
    always_comb begin
        b          = tok.data;
        pos_inc    = pos_reg + 9'd1;
        slen       = {b, len_reg[7:0]};
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        ferr_next  = ferr_reg;
        emit       = 1'b0;
        total_next = (total_reg < TOTAL_MAX) ? total_reg + 7'd1 : total_reg;
        if (ferr_reg == ST_OK) begin
            case (phase_reg)
                PH_MAGIC: begin
                    if (b != FRAME_MAGIC[pos_reg[1:0]]) begin
                        ferr_next = ST_MAGIC;
                    end else begin
                        emit     = 1'b1;
                        pos_next = pos_inc;
                        if (pos_inc >= MAGIC_BYTES) begin
                            phase_next = PH_VERSION;
                            pos_next   = 9'd0;
                            len_next   = 9'd0;
                        end
                    end
                end
                PH_VERSION: begin
                    if (b != FRAME_VERSION) begin
                        ferr_next = ST_VERSION;
                    end else begin
                        emit       = 1'b1;
                        phase_next = PH_ID_LEN;
                        pos_next   = 9'd0;
                        len_next   = 9'd0;
                    end
                end
                PH_ID_LEN, PH_EP_LEN: begin
                    if (b == 8'd0 || b > MAX_NAME_LEN) begin
                        ferr_next = (phase_reg == PH_ID_LEN) ? ST_ID : ST_ENDPOINT;
                    end else begin
                        emit       = 1'b1;
                        phase_next = (phase_reg == PH_ID_LEN) ? PH_ID : PH_EP;
                        pos_next   = 9'd0;
                        len_next   = {1'b0, b};
                    end
                end
                PH_ID, PH_EP: begin
                    emit     = 1'b1;
                    pos_next = pos_inc;
                    if (pos_inc >= len_reg) begin
                        phase_next = (phase_reg == PH_ID) ? PH_EP_LEN : PH_FLAGS;
                        pos_next   = 9'd0;
                    end
                end
                PH_FLAGS: begin
                    emit       = 1'b1;
                    pos_next   = 9'd0;
                    phase_next = b[0] ? PH_SIG_LO : PH_KEY;
                    len_next   = b[0] ? 9'd0 : KEY_BYTES;
                end
                PH_SIG_LO: begin
                    emit       = 1'b1;
                    phase_next = PH_SIG_HI;
                    pos_next   = 9'd0;
                    len_next   = {1'b0, b};
                end
                PH_SIG_HI: begin
                    if (slen > MAX_SIGNALING_LEN) begin
                        ferr_next = ST_SIGNALING;
                    end else begin
                        emit     = 1'b1;
                        pos_next = 9'd0;
                        if (slen == 16'd0) begin
                            phase_next = PH_KEY;
                            len_next   = KEY_BYTES;
                        end else begin
                            phase_next = PH_SIG;
                            len_next   = slen[8:0];
                        end
                    end
                end
                PH_SIG: begin
                    emit     = 1'b1;
                    pos_next = pos_inc;
                    if (pos_inc >= len_reg) begin
                        phase_next = PH_KEY;
                        pos_next   = 9'd0;
                        len_next   = KEY_BYTES;
                    end
                end
                PH_KEY: begin
                    emit     = 1'b1;
                    pos_next = pos_inc;
                    if (pos_inc >= KEY_BYTES) begin
                        phase_next = PH_SIGNATURE;
                        pos_next   = 9'd0;
                        len_next   = SIG_BYTES;
                    end
                end
                PH_SIGNATURE: begin
                    emit     = 1'b1;
                    pos_next = pos_inc;
                    if (pos_inc >= len_reg) begin
                        phase_next = PH_DONE;
                        pos_next   = 9'd0;
                    end
                end
                default: begin
                    ferr_next = ST_TAIL;
                end
            endcase
        end
    end

    // Sequencing: a token with a byte and the end mark may take two beats.
    always_comb begin
        out_free    = !m_valid_reg || m_ready;
        act         = tok_valid && out_free;
        byte_step   = tok.has_byte && !pend_reg;
        load_byte   = act && byte_step && emit;
        load_status = act && tok.last && !(byte_step && emit);
        tok_pop     = act && !(byte_step && emit && tok.last);
        clear_frame = load_status;
        pend_next   = load_byte && tok.last;
        tag_now     = phase_tag(phase_reg);
        if (byte_step) begin
            status_now = frame_status(tok.bad, total_next, ferr_next, phase_next);
        end else begin
            status_now = frame_status(tok.bad, total_reg, ferr_reg, phase_reg);
        end
        m_valid_next = (load_byte || load_status) ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_frame) begin
            phase_reg <= PH_MAGIC;
            pos_reg   <= 9'd0;
            len_reg   <= 9'd0;
            total_reg <= 7'd0;
            ferr_reg  <= ST_OK;
            pend_reg  <= 1'b0;
        end else if (act) begin
            pend_reg <= pend_next;
            if (byte_step) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                total_reg <= total_next;
                ferr_reg  <= ferr_next;
            end
        end
    end

    // Result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load_byte) begin
            is_status_reg <= 1'b0;
            tag_reg       <= tag_now;
            byte_reg      <= b;
            status_reg    <= ST_OK;
            ok_reg        <= 1'b0;
            lastr_reg     <= 1'b0;
        end else if (load_status) begin
            is_status_reg <= 1'b1;
            tag_reg       <= TAG_MAGIC;
            byte_reg      <= 8'd0;
            status_reg    <= status_now;
            ok_reg        <= (status_now == ST_OK);
            lastr_reg     <= 1'b1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_is_status   = is_status_reg;
    assign m_field_tag   = tag_reg;
    assign m_byte_value  = byte_reg;
    assign m_status_code = status_reg;
    assign m_frame_ok    = ok_reg;
    assign m_last_result = lastr_reg;

endmodule

>>> hdl/contact_frame_base64url_parser.sv
// Top level of the contact frame base64url parser: front decoder, token queue, frame parser.
// A character's result passes through the token queue, then the result register, to m_valid;
// the status beat of a last character that also yields a byte follows its byte beat.
// Throughput: one character per cycle when the queue has room; a last character that also
// yields a byte needs two output beats; results leave only through the output register.
// The queue between decoder and parser lets the input keep flowing during output stalls.
// Reset: synchronous, active low; clears decoder, queue and parser state, no result valid.
module contact_frame_base64url_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_status,
    output logic [3:0]  m_field_tag,
    output logic [7:0]  m_byte_value,
    output logic [3:0]  m_status_code,
    output logic        m_frame_ok,
    output logic        m_last_result
);
    import cfbp_pkg::*;

    logic   push_valid;
    logic   push_ready;
    token_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    token_t pop_data;

    // Character decoder.
    cfbp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last_char (s_last_char),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // Token queue.
    cfbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Frame parser and result register.
    cfbp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tok_valid     (pop_valid),
        .tok_pop       (pop_ready),
        .tok           (pop_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_status   (m_is_status),
        .m_field_tag   (m_field_tag),
        .m_byte_value  (m_byte_value),
        .m_status_code (m_status_code),
        .m_frame_ok    (m_frame_ok),
        .m_last_result (m_last_result)
    );

    // A status beat is final, carries no byte, and reports ok exactly for status ok.
    a_status_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_status |->
            m_last_result && (m_frame_ok == (m_status_code == ST_OK)) &&
            (m_field_tag == TAG_MAGIC) && (m_byte_value == 8'd0))
        else $error("malformed status beat");

    // A byte beat carries a defined tag and no status information.
    a_byte_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_status |->
            !m_last_result && !m_frame_ok && (m_status_code == ST_OK) &&
            (m_field_tag <= TAG_SIGNATURE))
        else $error("malformed byte beat");

endmodule

>>> dv/contact_frame_base64url_parser_checker.sv
// Checker for the contact frame parser: predicts every result beat and compares it.
module contact_frame_base64url_parser_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_last_char,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_is_status,
    input  logic [3:0] m_field_tag,
    input  logic [7:0] m_byte_value,
    input  logic [3:0] m_status_code,
    input  logic       m_frame_ok,
    input  logic       m_last_result,
    output int         mismatch_count,
    output int         pending_results
);
    import cfbp_pkg::*;

    // Phase after the last signature byte: the frame is complete.
    localparam logic [3:0] PHASE_DONE = 4'd12;
    localparam logic [31:0] MAGIC_WORD = 32'h4C50_5131;

    typedef struct packed {
        logic       is_status;
        logic [3:0] tag;
        logic [7:0] value;
        logic [3:0] code;
        logic       ok;
        logic       fin;
    } parser_result_t;

    parser_result_t expected_results[$];

    // Predicted decoder and frame parser state.
    logic [5:0] carry_bits;
    logic [2:0] carry_count;
    logic [3:0] field_phase;
    logic [8:0] field_pos;
    logic [8:0] field_len;
    logic [6:0] byte_count;
    logic [3:0] first_fault;
    logic       saw_bad_char;

    int failures = 0;
    int waiting = 0;
    int result_beats = 0;

    assign mismatch_count  = failures;
    assign pending_results = waiting;

    task automatic report_mismatch(input string what);
        failures++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // A new text starts from a clean decoder and the magic phase.
    task automatic clear_text_state();
        carry_bits   = '0;
        carry_count  = '0;
        field_phase  = TAG_MAGIC;
        field_pos    = '0;
        field_len    = '0;
        byte_count   = '0;
        first_fault  = ST_OK;
        saw_bad_char = 1'b0;
    endtask

    task automatic start_field(input logic [3:0] next_phase, input logic [8:0] len);
        field_phase = next_phase;
        field_pos   = '0;
        field_len   = len;
    endtask

    task automatic count_in_field(input logic [3:0] next_phase);
        field_pos = field_pos + 9'd1;
        if (field_pos >= field_len) begin
            field_phase = next_phase;
            field_pos   = '0;
        end
    endtask

    // Parses one decoded byte; emit is low when the byte raises a structural error.
    task automatic parse_frame_byte(input logic [7:0] b, output logic emit);
        logic [15:0] sig_len;
        emit = 1'b1;
        sig_len = {b, field_len[7:0]};
        case (field_phase)
            TAG_MAGIC: begin
                if (b != MAGIC_WORD[31 - 8 * field_pos[1:0] -: 8]) begin
                    first_fault = ST_MAGIC;
                    emit = 1'b0;
                end else begin
                    field_pos = field_pos + 9'd1;
                    if (field_pos >= MAGIC_BYTES) start_field(TAG_VERSION, 9'd0);
                end
            end
            TAG_VERSION: begin
                if (b != FRAME_VERSION) begin
                    first_fault = ST_VERSION;
                    emit = 1'b0;
                end else begin
                    start_field(TAG_ID_LEN, 9'd0);
                end
            end
            TAG_ID_LEN: begin
                if (b == 8'd0 || b > MAX_NAME_LEN) begin
                    first_fault = ST_ID;
                    emit = 1'b0;
                end else begin
                    start_field(TAG_ID, {1'b0, b});
                end
            end
            TAG_ID: count_in_field(TAG_EP_LEN);
            TAG_EP_LEN: begin
                if (b == 8'd0 || b > MAX_NAME_LEN) begin
                    first_fault = ST_ENDPOINT;
                    emit = 1'b0;
                end else begin
                    start_field(TAG_EP, {1'b0, b});
                end
            end
            TAG_EP: count_in_field(TAG_FLAGS);
            TAG_FLAGS: begin
                if (b[0]) start_field(TAG_SIG_LO, 9'd0);
                else start_field(TAG_KEY, KEY_BYTES);
            end
            TAG_SIG_LO: start_field(TAG_SIG_HI, {1'b0, b});
            TAG_SIG_HI: begin
                if (sig_len > MAX_SIGNALING_LEN) begin
                    first_fault = ST_SIGNALING;
                    emit = 1'b0;
                end else if (sig_len == 16'd0) begin
                    start_field(TAG_KEY, KEY_BYTES);
                end else begin
                    start_field(TAG_SIGNALING, sig_len[8:0]);
                end
            end
            TAG_SIGNALING: begin
                field_pos = field_pos + 9'd1;
                if (field_pos >= field_len) start_field(TAG_KEY, KEY_BYTES);
            end
            TAG_KEY: begin
                field_pos = field_pos + 9'd1;
                if (field_pos >= KEY_BYTES) start_field(TAG_SIGNATURE, SIG_BYTES);
            end
            TAG_SIGNATURE: count_in_field(PHASE_DONE);
            default: begin
                // Anything after the signature is a tail error.
                first_fault = ST_TAIL;
                emit = 1'b0;
            end
        endcase
    endtask

    // Works out the result beats caused by one accepted character.
    task automatic predict_char_results(input logic [7:0] ch, input logic fin);
        int             sextet;
        int             bits_held;
        logic [11:0]    shift_buf;
        logic [11:0]    shifted;
        logic [11:0]    kept;
        logic [3:0]     tag;
        logic [3:0]     code;
        logic           emit;
        parser_result_t r;
        if (!saw_bad_char) begin
            if (ch >= "A" && ch <= "Z") sextet = ch - "A";
            else if (ch >= "a" && ch <= "z") sextet = ch - "a" + 26;
            else if (ch >= "0" && ch <= "9") sextet = ch - "0" + 52;
            else if (ch == "-") sextet = 62;
            else if (ch == "_") sextet = 63;
            else sextet = -1;

            if (sextet < 0) begin
                saw_bad_char = 1'b1;
            end else begin
                shift_buf = {carry_bits, sextet[5:0]};
                bits_held = carry_count + 6;
                if (bits_held >= 8) begin
                    bits_held = bits_held - 8;
                    shifted = shift_buf >> bits_held;
                    if (byte_count < TOTAL_MAX) byte_count = byte_count + 7'd1;
                    if (first_fault == ST_OK) begin
                        tag = field_phase;
                        parse_frame_byte(shifted[7:0], emit);
                        if (emit) begin
                            r.is_status = 1'b0;
                            r.tag       = tag;
                            r.value     = shifted[7:0];
                            r.code      = ST_OK;
                            r.ok        = 1'b0;
                            r.fin       = 1'b0;
                            expected_results.insert(expected_results.size(), r);
                        end
                    end
                end
                // Leftover bits stay for the next character.
                kept = shift_buf & ((12'd1 << bits_held) - 12'd1);
                carry_count = bits_held[2:0];
                carry_bits  = kept[5:0];
            end
        end

        if (fin) begin
            if (saw_bad_char) code = ST_BAD_CHAR;
            else if (byte_count < MIN_FRAME) code = ST_SHORT;
            else if (first_fault != ST_OK) code = first_fault;
            else begin
                case (field_phase)
                    TAG_ID: code = ST_ID;
                    TAG_EP_LEN, TAG_EP: code = ST_ENDPOINT;
                    TAG_FLAGS: code = ST_TAIL;
                    TAG_SIG_LO, TAG_SIG_HI, TAG_SIGNALING: code = ST_SIGNALING;
                    TAG_KEY, TAG_SIGNATURE: code = ST_TAIL;
                    PHASE_DONE: code = ST_OK;
                    default: code = ST_SHORT;
                endcase
            end
            r.is_status = 1'b1;
            r.tag       = TAG_MAGIC;
            r.value     = 8'h00;
            r.code      = code;
            r.ok        = (code == ST_OK);
            r.fin       = 1'b1;
            expected_results.insert(expected_results.size(), r);
            clear_text_state();
        end
    endtask

    initial clear_text_state();

    // Sample at the falling edge: a beat seen here is taken at the next rising edge.
    always @(negedge aclk) begin
        parser_result_t got;
        parser_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) predict_char_results(s_character, s_last_char);
            if (m_valid && m_ready) begin
                got.is_status = m_is_status;
                got.tag       = m_field_tag;
                got.value     = m_byte_value;
                got.code      = m_status_code;
                got.ok        = m_frame_ok;
                got.fin       = m_last_result;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                              result_beats));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf({"result beat %0d: got st=%0b tag=%0d ",
                            "byte=%02h code=%0d ok=%0b last=%0b, want st=%0b tag=%0d ",
                            "byte=%02h code=%0d ok=%0b last=%0b"}, result_beats,
                            got.is_status, got.tag, got.value, got.code, got.ok, got.fin,
                            want.is_status, want.tag, want.value, want.code, want.ok,
                            want.fin));
                    end
                end
                result_beats++;
            end
            waiting = expected_results.size();
        end
    end

endmodule

>>> dv/contact_frame_base64url_parser_tb.sv
// Testbench top for the contact frame parser: clock, reset, character stimulus and verdict.
module contact_frame_base64url_parser_tb;

    localparam int CHAR_GOAL       = 2015;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;

    // Kinds of text sent in the random part.
    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_ID_LEN,
        FLAW_EP_LEN,
        FLAW_SIG_LEN,
        FLAW_TRUNCATE,
        FLAW_TAIL,
        FLAW_BAD_CHAR,
        FLAW_NOISE
    } text_flaw_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_character = 8'h00;
    logic       s_last_char = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_is_status;
    logic [3:0] m_field_tag;
    logic [7:0] m_byte_value;
    logic [3:0] m_status_code;
    logic       m_frame_ok;
    logic       m_last_result;

    int mismatch_count;
    int pending_results;

    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    bit  pressure_request = 1'b0;
    bit  hold_off = 1'b0;
    int  chars_sent = 0;

    logic [7:0] frame_bytes[$];
    logic [7:0] text_chars[$];

    always #4 aclk = ~aclk;

    contact_frame_base64url_parser u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_character   (s_character),
        .s_last_char   (s_last_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_status   (m_is_status),
        .m_field_tag   (m_field_tag),
        .m_byte_value  (m_byte_value),
        .m_status_code (m_status_code),
        .m_frame_ok    (m_frame_ok),
        .m_last_result (m_last_result)
    );

    contact_frame_base64url_parser_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_character     (s_character),
        .s_last_char     (s_last_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_status     (m_is_status),
        .m_field_tag     (m_field_tag),
        .m_byte_value    (m_byte_value),
        .m_status_code   (m_status_code),
        .m_frame_ok      (m_frame_ok),
        .m_last_result   (m_last_result),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Result side: random stalls, or held off completely during the pressure stretch.
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Long receiver hold-off, counted on the falling edge so it never races the driver.
    initial begin
        wait (pressure_request);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge aclk);
        hold_off = 1'b0;
    end

    // Watchdog for a hung run.
    initial begin
        #4_000_000;
        $display("contact_frame_base64url_parser test failed");
        $finish;
    end

    // Offers one character and returns at the rising edge that takes the beat.
    task automatic send_char(input logic [7:0] ch, input logic fin);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= ch;
        s_last_char <= fin;
        do begin
            @(negedge aclk);
            taken = s_valid && s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_chars.size(); i++)
            send_char(text_chars[i], i == text_chars.size() - 1);
        chars_sent += text_chars.size();
    endtask

    task automatic send_string(input string txt);
        int i;
        text_chars.delete();
        for (i = 0; i < txt.len(); i++) text_chars.insert(text_chars.size(), txt[i]);
        send_text();
    endtask

    // Builds a contact frame with random content, spoils it as asked and encodes it.
    task automatic make_text(input text_flaw_t flaw);
        int         id_len;
        int         ep_len;
        int         sig_len;
        int         ep_len_at;
        int         sig_at;
        int         n;
        int         j;
        int         span;
        int         sextet;
        int         pick;
        bit         big;
        logic [7:0] flags;
        logic [7:0] junk;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] ch_code;
        logic [23:0] group;
        frame_bytes.delete();
        text_chars.delete();
        if (flaw == FLAW_NOISE) begin
            // Short text of arbitrary characters.
            repeat ($urandom_range(1, 16))
                text_chars.insert(text_chars.size(), 8'($urandom_range(255)));
        end else begin
            big     = ($urandom_range(24) == 0);
            id_len  = big ? 128 : $urandom_range(1, 6);
            ep_len  = big ? 128 : $urandom_range(1, 6);
            flags   = 8'($urandom_range(255));
            if (flaw == FLAW_SIG_LEN) flags[0] = 1'b1;
            if (big) sig_len = 256;
            else if ($urandom_range(3) == 0) sig_len = 0;
            else sig_len = $urandom_range(1, 8);
            sig_at = 0;

            frame_bytes.insert(frame_bytes.size(), "L");
            frame_bytes.insert(frame_bytes.size(), "P");
            frame_bytes.insert(frame_bytes.size(), "Q");
            frame_bytes.insert(frame_bytes.size(), "1");
            frame_bytes.insert(frame_bytes.size(), 8'h01);
            frame_bytes.insert(frame_bytes.size(), id_len[7:0]);
            repeat (id_len) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
            ep_len_at = frame_bytes.size();
            frame_bytes.insert(frame_bytes.size(), ep_len[7:0]);
            repeat (ep_len) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
            frame_bytes.insert(frame_bytes.size(), flags);
            if (flags[0]) begin
                sig_at = frame_bytes.size();
                frame_bytes.insert(frame_bytes.size(), sig_len[7:0]);
                frame_bytes.insert(frame_bytes.size(), sig_len[15:8]);
                repeat (sig_len)
                    frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
            end
            // Key and signature bytes.
            repeat (96) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));

            case (flaw)
                FLAW_MAGIC: begin
                    pick = $urandom_range(3);
                    frame_bytes[pick] = frame_bytes[pick] ^ 8'($urandom_range(1, 255));
                end
                FLAW_VERSION: frame_bytes[4] = frame_bytes[4] ^ 8'($urandom_range(1, 255));
                FLAW_ID_LEN:
                    frame_bytes[5] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(129, 255));
                FLAW_EP_LEN: frame_bytes[ep_len_at] =
                    $urandom_range(1) ? 8'h00 : 8'($urandom_range(129, 255));
                FLAW_SIG_LEN: begin
                    // Any length above 256.
                    frame_bytes[sig_at + 1] = 8'($urandom_range(1, 255));
                    if (frame_bytes[sig_at + 1] == 8'h01)
                        frame_bytes[sig_at] = 8'($urandom_range(1, 255));
                end
                FLAW_TRUNCATE: repeat ($urandom_range(1, frame_bytes.size() - 1))
                    void'(frame_bytes.pop_back());
                FLAW_TAIL: repeat ($urandom_range(1, 3))
                    frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
                default: ;
            endcase

            // Unpadded base64url: three bytes give four characters.
            for (n = 0; n < frame_bytes.size(); n += 3) begin
                b1 = (n + 1 < frame_bytes.size()) ? frame_bytes[n + 1] : 8'h00;
                b2 = (n + 2 < frame_bytes.size()) ? frame_bytes[n + 2] : 8'h00;
                group = {frame_bytes[n], b1, b2};
                span = (frame_bytes.size() - n >= 3) ? 4 : frame_bytes.size() - n + 1;
                for (j = 0; j < span; j++) begin
                    sextet = group[23 - 6 * j -: 6];
                    if (sextet < 26) ch_code = 8'("A" + sextet);
                    else if (sextet < 52) ch_code = 8'("a" + sextet - 26);
                    else if (sextet < 62) ch_code = 8'("0" + sextet - 52);
                    else if (sextet == 62) ch_code = "-";
                    else ch_code = "_";
                    text_chars.insert(text_chars.size(), ch_code);
                end
            end

            if (flaw == FLAW_BAD_CHAR) begin
                do junk = 8'($urandom_range(255));
                while ((junk >= "A" && junk <= "Z") || (junk >= "a" && junk <= "z") ||
                       (junk >= "0" && junk <= "9") || junk == "-" || junk == "_");
                text_chars[$urandom_range(text_chars.size() - 1)] = junk;
            end
        end
    endtask

    initial begin
        int         text_index;
        text_flaw_t flaw;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed texts: a lone character, the magic with trailing bits,
        // a bad character in mid text, the lowest and highest codes, and the two
        // symbol characters of the alphabet.
        send_string("A");
        send_string("TFBRMQ");
        send_string("TF=B");
        text_chars = '{8'h00};
        send_text();
        text_chars = '{8'hFF};
        send_text();
        send_string("-_");

        // Random texts, mostly well-formed frames.
        text_index = 0;
        while (chars_sent < CHAR_GOAL) begin
            case (text_index % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
                default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
            endcase
            if (text_index == 2) begin
                // Keep offering characters while the result side is held off.
                sender_idle_pct  = 0;
                pressure_request = 1'b1;
                flaw = FLAW_NONE;
            end else if ($urandom_range(99) < 55) begin
                flaw = FLAW_NONE;
            end else begin
                flaw = text_flaw_t'($urandom_range(FLAW_MAGIC, FLAW_NOISE));
            end
            make_text(flaw);
            send_text();
            text_index++;
        end
        s_valid <= 1'b0;

        while (pending_results != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) $display("contact_frame_base64url_parser test passed");
        else $display("contact_frame_base64url_parser test failed");
        $finish;
    end

endmodule
